/* rtl/lbs_pkg.sv */
// Shared constants, types and arithmetic helpers for the skinning engine.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

  localparam int JOINTS_DEF     = 64;
  localparam int MAX_INFL_DEF   = 8;
  localparam int ELEMS          = 12;
  localparam int DATA_W         = 32;
  localparam int ACC_W          = 48;
  localparam int ROW_W          = 50;
  localparam int WEIGHT_W       = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic CMD_PALETTE   = 1'b0;
  localparam logic CMD_INFLUENCE = 1'b1;

  localparam logic REG_JOINT_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ADD,
    ST_WMUL,
    ST_WACC,
    ST_FIN
  } lbs_state_t;

  function automatic logic signed [31:0] sat32_row(input logic signed [ROW_W-1:0] x);
    if (x > 50'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -50'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(x);
  endfunction

  function automatic logic signed [31:0] sat32_acc(input logic signed [ACC_W-1:0] x);
    if (x > 48'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -48'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(x);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] x);
    if (x > 49'sh07FFFFFFFFFFF) begin
      return 48'sh7FFFFFFFFFFF;
    end else if (x < -49'sh0800000000000) begin
      return 48'sh800000000000;
    end
    return 48'(x);
  endfunction

endpackage
`default_nettype wire

/* rtl/lbs_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/linear_blend_skinning.sv */
// Top level of the linear blend skinning engine: sequencer, datapath, palette RAM.
//
//   channel  direction  signals
//   in       request    in_valid / in_ready, cmd .. last_influence
//   out      result     out_valid / out_ready, out_x, out_y, out_z, bad_joint
//   apb      config     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A palette write or a skipped influence completes on acceptance. A weighted influence
// steps through the accept, twelve palette reads on the single RAM read port and one
// shared multiplier (translation read in ST_READ / ST_MUL, each column read / multiply / add
// in ST_READ / ST_MUL / ST_ADD), then ST_WMUL / ST_WACC for each weight scale.
// A last influence adds the ST_FIN state and waits there while an earlier result is not taken.
// Reset is synchronous; palette contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_skinning #(
  parameter int JOINTS         = lbs_pkg::JOINTS_DEF,
  parameter int MAX_INFLUENCES = lbs_pkg::MAX_INFL_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               cmd,
  input  wire logic        [5:0]  joint_index,
  input  wire logic        [3:0]  element_index,
  input  wire logic signed [31:0] element_value,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic        [16:0] weight,
  input  wire logic               last_influence,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed      [31:0] out_x,
  output logic signed      [31:0] out_y,
  output logic signed      [31:0] out_z,
  output logic                    bad_joint,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [2:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  import lbs_pkg::*;

  localparam int DEPTH = JOINTS * ELEMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_INFLUENCES + 1);

  lbs_state_t state, state_next;

  logic [6:0]  joint_count;
  logic [CW-1:0] infl_cnt;
  logic        error_seen;
  logic        last_r;
  logic [AW-1:0] base;
  logic [1:0]  row;
  logic [1:0]  col;
  logic signed [31:0] px, py, pz;
  logic [WEIGHT_W-1:0] wgt;
  logic signed [63:0] prod;
  logic signed [ROW_W-1:0] rowsum;
  logic signed [31:0] wrow [3];
  logic signed [ACC_W-1:0] acc [3];

  logic in_acc, cnt_ok, nz, bad, go_calc, pal_we, fin_go;
  logic [AW-1:0] raddr, waddr;
  logic [31:0] rdata;
  logic [1:0]  cm1;
  logic [3:0]  k;
  logic signed [31:0] pos_sel;
  logic signed [ROW_W-1:0] row_add;
  logic signed [ACC_W:0] acc_add;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_JOINT_COUNT) ? {25'd0, joint_count} : 32'd0;
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign fin_go   = (state == ST_FIN) && (!out_valid || out_ready);

  assign cnt_ok  = 32'(infl_cnt) < MAX_INFLUENCES;
  assign nz      = (weight != '0);
  assign bad     = ({1'b0, joint_index} >= joint_count) || (32'(joint_index) >= JOINTS);
  assign go_calc = cnt_ok && nz && !bad;

  assign pal_we = in_acc && (cmd == CMD_PALETTE) && (32'(element_index) < ELEMS)
                  && (32'(joint_index) < JOINTS);
  assign waddr  = AW'(32'(joint_index) * ELEMS + 32'(element_index));

  assign cm1   = col - 2'd1;
  assign k     = 4'(row) + ((col == 2'd0) ? 4'd9 : (4'({cm1, 1'b0}) + 4'(cm1)));
  assign raddr = base + AW'(k);

  always_comb begin
    case (col)
      2'd1:    pos_sel = px;
      2'd2:    pos_sel = py;
      default: pos_sel = pz;
    endcase
  end

  assign row_add = rowsum + ROW_W'(prod >>> 16);
  assign acc_add = {acc[row][ACC_W-1], acc[row]} + (ACC_W+1)'(prod >>> 16);

  lbs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_INFLUENCE) begin
          if (go_calc) begin
            state_next = ST_READ;
          end else if (last_influence) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = (col == 2'd0) ? ST_READ : ST_ADD;
      ST_ADD: begin
        if (col != 2'd3) begin
          state_next = ST_READ;
        end else if (row == 2'd2) begin
          state_next = ST_WMUL;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_WMUL: state_next = ST_WACC;
      ST_WACC: begin
        if (row != 2'd2) begin
          state_next = ST_WMUL;
        end else begin
          state_next = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN:  state_next = fin_go ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_JOINT_COUNT) begin
      joint_count <= pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      infl_cnt   <= '0;
      error_seen <= 1'b0;
      last_r     <= 1'b0;
      row        <= '0;
      col        <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc[i] <= '0;
      end
    end else begin
      out_valid <= fin_go || (out_valid && !out_ready);
      case (state)
        ST_IDLE: begin
          if (in_acc && cmd == CMD_INFLUENCE) begin
            last_r <= last_influence;
            if (cnt_ok) begin
              infl_cnt <= infl_cnt + CW'(1);
            end
            if (cnt_ok && nz && bad) begin
              error_seen <= 1'b1;
            end
            row <= '0;
            col <= '0;
          end
        end
        ST_MUL: begin
          if (col == 2'd0) begin
            col <= 2'd1;
          end
        end
        ST_ADD: begin
          if (col == 2'd3) begin
            col <= '0;
            row <= (row == 2'd2) ? 2'd0 : row + 2'd1;
          end else begin
            col <= col + 2'd1;
          end
        end
        ST_WACC: begin
          acc[row] <= sat48(acc_add);
          row <= row + 2'd1;
        end
        ST_FIN: begin
          if (fin_go) begin
            infl_cnt   <= '0;
            error_seen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              acc[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px   <= pos_x;
        py   <= pos_y;
        pz   <= pos_z;
        wgt  <= (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
        base <= AW'(32'(joint_index) * ELEMS);
      end
      ST_MUL: begin
        if (col == 2'd0) begin
          rowsum <= ROW_W'($signed(rdata));
        end else begin
          prod <= $signed(rdata) * pos_sel;
        end
      end
      ST_ADD: begin
        rowsum <= row_add;
        if (col == 2'd3) begin
          wrow[row] <= sat32_row(row_add);
        end
      end
      ST_WMUL: prod <= wrow[row] * $signed({1'b0, wgt});
      ST_FIN: begin
        if (fin_go) begin
          out_x     <= sat32_acc(acc[0]);
          out_y     <= sat32_acc(acc[1]);
          out_z     <= sat32_acc(acc[2]);
          bad_joint <= error_seen;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_pal_we_on_accept: assert property (@(posedge clk) disable iff (rst)
    pal_we |-> (in_valid && in_ready && cmd == CMD_PALETTE))
    else $error("palette written outside a palette request");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (out_valid && acc[0] == '0 && acc[1] == '0 && acc[2] == '0 && !error_seen))
    else $error("result emitted without clearing the accumulation");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(infl_cnt) <= MAX_INFLUENCES)
    else $error("influence count overran");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WACC && row == 2'd2 && !last_r) |=> (state == ST_IDLE))
    else $error("sequencer did not return to idle after an influence");
`endif

endmodule
`default_nettype wire

/* tb/linear_blend_skinning_tb.sv */
// Self-checking testbench for the skinning engine: palette load, vertex streams, APB joint_count.
`timescale 1ns / 1ps
module linear_blend_skinning_tb;
  import lbs_pkg::*;

  typedef struct {
    logic        cmd;
    logic [5:0]  joint;
    logic [3:0]  elem;
    logic [31:0] value;
    logic [31:0] px, py, pz;
    logic [16:0] wt;
    logic        last;
  } request_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        bad;
  } skinned_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [5:0] joint_index = '0;
  logic [3:0] element_index = '0;
  logic signed [31:0] element_value = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [16:0] weight = '0;
  logic last_influence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic bad_joint;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  request_t pending[$];
  skinned_t skinned_q[$];

  logic signed [31:0] palette[JOINTS_DEF*ELEMS];
  longint acc_x, acc_y, acc_z;
  bit     err_seen;
  int     infl_cnt;
  int     jc_model;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_req = 0;
  int hold_left = 0;
  int errors = 0;

  linear_blend_skinning dut (.*);

  always #5 clk = ~clk;

  task automatic enqueue(request_t q);
    pending.insert(pending.size(), q);
  endtask

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
    if (v < -64'sh800000000000) return -64'sh800000000000;
    return v;
  endfunction

  function automatic longint row_sum(int j, int r, longint p[3]);
    longint s;
    s = longint'(palette[j*ELEMS + r + 9]);
    for (int c = 0; c < 3; c++)
      s += floor16(longint'(palette[j*ELEMS + r + 3*c]) * p[c]);
    return clamp32(s);
  endfunction

  task automatic skin_request(request_t q);
    longint p[3];
    longint w;
    skinned_t e;
    if (q.cmd == CMD_PALETTE) begin
      if (q.elem < ELEMS) palette[q.joint*ELEMS + q.elem] = q.value;
      return;
    end
    w = (q.wt > WEIGHT_ONE) ? 65536 : longint'(q.wt);
    if (infl_cnt < MAX_INFL_DEF && w != 0) begin
      if (q.joint >= jc_model) begin
        err_seen = 1;
      end else begin
        p[0] = longint'($signed(q.px));
        p[1] = longint'($signed(q.py));
        p[2] = longint'($signed(q.pz));
        acc_x = clamp48(acc_x + floor16(row_sum(q.joint, 0, p) * w));
        acc_y = clamp48(acc_y + floor16(row_sum(q.joint, 1, p) * w));
        acc_z = clamp48(acc_z + floor16(row_sum(q.joint, 2, p) * w));
      end
    end
    if (infl_cnt < MAX_INFL_DEF) infl_cnt++;
    if (!q.last) return;
    e.x = 32'(clamp32(acc_x));
    e.y = 32'(clamp32(acc_y));
    e.z = 32'(clamp32(acc_z));
    e.bad = err_seen;
    skinned_q.insert(skinned_q.size(), e);
    acc_x = 0; acc_y = 0; acc_z = 0;
    err_seen = 0;
    infl_cnt = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        skin_request('{cmd, joint_index, element_index, element_value,
                       pos_x, pos_y, pos_z, weight, last_influence});
      end
      if (!in_valid || in_ready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          request_t q;
          q = pending.pop_front();
          cmd <= q.cmd;
          joint_index <= q.joint;
          element_index <= q.elem;
          element_value <= q.value;
          pos_x <= q.px;
          pos_y <= q.py;
          pos_z <= q.pz;
          weight <= q.wt;
          last_influence <= q.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stalls plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold_req && hold_left < 600) begin
      hold_left <= hold_left + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (skinned_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h bad=%b", $time,
                 out_x, out_y, out_z, bad_joint);
        errors++;
      end else begin
        skinned_t e;
        e = skinned_q.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
          errors++;
        end
        if (bad_joint !== e.bad) begin
          $display("%0t: bad_joint expected %b actual %b", $time, e.bad, bad_joint);
          errors++;
        end
      end
    end
  end

  function automatic request_t palette_req(int j, int el, logic [31:0] v);
    request_t q;
    q = '{default: '0};
    q.cmd = CMD_PALETTE;
    q.joint = 6'(j);
    q.elem = 4'(el);
    q.value = v;
    return q;
  endfunction

  function automatic request_t infl_req(int j, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, int w, bit last);
    request_t q;
    q = '{default: '0};
    q.cmd = CMD_INFLUENCE;
    q.joint = 6'(j);
    q.elem = 4'($urandom);
    q.value = $urandom;
    q.px = x; q.py = y; q.pz = z;
    q.wt = 17'(w);
    q.last = last;
    return q;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(9) < 8) return 32'($urandom_range(0, 1 << 22) - (1 << 21));
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_elem_value();
    if ($urandom_range(9) < 7) return 32'($urandom_range(0, 1 << 19) - (1 << 18));
    return $urandom;
  endfunction

  task automatic push_vertex(int jc);
    int n, w, j;
    logic [31:0] x, y, z;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    x = rand_coord(); y = rand_coord(); z = rand_coord();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(11) == 0)
        enqueue(palette_req($urandom_range(63), $urandom_range(15),
                            rand_elem_value()));
      case ($urandom_range(9))
        0: w = 0;
        1: w = 65536;
        2: w = $urandom_range(65537, 131071);
        default: w = $urandom_range(1, 65535);
      endcase
      j = (jc > 0 && $urandom_range(9) < 9) ? $urandom_range(jc - 1) : $urandom_range(63);
      enqueue(infl_req(j, x, y, z, w, i == n - 1));
    end
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || skinned_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_joint_count(int v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_JOINT_COUNT); pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    jc_model = v;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int jc_list[6];
    int target;
    jc_list = '{64, 0, 1, 37, 64, 0};
    acc_x = 0; acc_y = 0; acc_z = 0; err_seen = 0; infl_cnt = 0; jc_model = 0;
    foreach (palette[i]) palette[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_joint_count(64);

    for (int j = 0; j < JOINTS_DEF; j++)
      for (int k = 0; k < ELEMS; k++)
        enqueue(palette_req(j, k, rand_elem_value()));

    // directed: identity joint, saturating joint, special cases
    for (int k = 0; k < ELEMS; k++) begin
      enqueue(palette_req(0, k, (k == 0 || k == 4 || k == 8) ? 32'h10000 : 32'h0));
      enqueue(palette_req(63, k, 32'h7FFFFFFF));
    end
    enqueue(palette_req(5, 12, 32'hFFFFFFFF));
    enqueue(palette_req(5, 15, 32'h12345678));
    enqueue(infl_req(0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 65536, 1));
    enqueue(infl_req(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 65536, 0));
    enqueue(infl_req(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 131071, 1));
    enqueue(infl_req(0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    enqueue(infl_req(3, 32'h00030000, 32'hFFFF0000, 32'h0, 32768, 0));
    enqueue(palette_req(7, 2, 32'h00020000));
    enqueue(infl_req(7, 32'h00030000, 32'hFFFF0000, 32'h0, 1, 1));
    for (int i = 0; i < 10; i++)
      enqueue(infl_req(i, 32'h00010000, 32'h00020000, 32'h00030000, 40000, i == 9));
    drain();
    write_joint_count(20);
    enqueue(infl_req(20, 32'h1, 32'h1, 32'h1, 65536, 0));
    enqueue(infl_req(19, 32'h00010000, 32'h1, 32'h1, 65536, 0));
    enqueue(infl_req(63, 32'h1, 32'h1, 32'h1, 0, 1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_joint_count(ph == 4 ? $urandom_range(2, 63) : jc_list[ph]);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 27 : 48) : 0;
      recv_stall_pct = (ph % 4 == 2) ? 48 : ((ph % 4 == 3) ? 27 : 0);
      target = pending.size() + 168;
      if (ph == 2) long_hold_req = 1;
      while (pending.size() < target) begin
        if ($urandom_range(15) == 0)
          enqueue(palette_req($urandom_range(63), $urandom_range(11),
                              rand_elem_value()));
        else if ($urandom_range(31) == 0)
          enqueue(palette_req($urandom_range(63), $urandom_range(12, 15),
                              $urandom));
        else
          push_vertex(jc_model);
      end
      drain();
    end

    if (errors == 0) begin
      $display("linear_blend_skinning_tb: done, clean");
    end else begin
      $display("linear_blend_skinning_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("linear_blend_skinning_tb: done, errors");
    $finish;
  end

endmodule
